// ===== hw/rtl/esctok_pkg.sv =====
// ----------------------------------------------------------------------------
// esctok_pkg
// Shared types and constants of the escape sequence tokenizer: token kinds,
// parser modes and the records passed between the step logic and the queue.
// ----------------------------------------------------------------------------
package esctok_pkg;

   // Token kinds carried on the result channel.
   localparam logic [3:0] KIND_SYMBOL    = 4'd0;
   localparam logic [3:0] KIND_NEXTLINE  = 4'd1;
   localparam logic [3:0] KIND_CLEAN     = 4'd2;
   localparam logic [3:0] KIND_DELETE    = 4'd3;
   localparam logic [3:0] KIND_ERASE     = 4'd4;
   localparam logic [3:0] KIND_BACKSLASH = 4'd5;
   localparam logic [3:0] KIND_PAUSE     = 4'd6;
   localparam logic [3:0] KIND_COLOUR    = 4'd7;
   localparam logic [3:0] KIND_DONE      = 4'd8;
   localparam logic [3:0] KIND_ERROR     = 4'd9;

   // Parser modes.
   localparam logic [2:0] MODE_NORMAL      = 3'd0;
   localparam logic [2:0] MODE_ESCAPE      = 3'd1;
   localparam logic [2:0] MODE_PAUSE_FIRST = 3'd2;
   localparam logic [2:0] MODE_PAUSE_MORE  = 3'd3;
   localparam logic [2:0] MODE_COLOUR      = 3'd4;
   localparam logic [2:0] MODE_DRAIN       = 3'd5;

   // Characters with a meaning of their own.
   localparam logic [15:0] CHAR_NUL       = 16'h0000;
   localparam logic [15:0] CHAR_NEWLINE   = 16'h000a;
   localparam logic [15:0] CHAR_BACKSLASH = 16'h005c;
   localparam logic [15:0] CHAR_N         = 16'h006e;
   localparam logic [15:0] CHAR_A         = 16'h0061;
   localparam logic [15:0] CHAR_DASH      = 16'h002d;
   localparam logic [15:0] CHAR_LT        = 16'h003c;
   localparam logic [15:0] CHAR_P         = 16'h0070;
   localparam logic [15:0] CHAR_C         = 16'h0063;
   localparam logic [15:0] CHAR_ZERO      = 16'h0030;
   localparam logic [15:0] CHAR_NINE      = 16'h0039;
   localparam logic [15:0] CHAR_F         = 16'h0066;

   localparam logic [2:0] COLOUR_DIGITS = 3'd6;
   localparam int unsigned BATCH_DEPTH  = 3;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] symbol_code;
      logic [23:0] value;
      logic [15:0] error_position;
   } rsp_type;

   // All results caused by one request, in order.
   typedef struct packed {
      rsp_type [BATCH_DEPTH-1:0] item;
      logic [1:0]                count;
   } batch_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  digit_count;
      logic [23:0] acc;
      logic [15:0] escape_start;
   } state_type;

   typedef struct packed {
      state_type state;
      batch_type batch;
   } step_type;

   function automatic rsp_type make_rsp(logic [3:0] kind, logic [15:0] sym,
                                        logic [23:0] val, logic [15:0] pos);
      rsp_type r;
      r.kind           = kind;
      r.symbol_code    = sym;
      r.value          = val;
      r.error_position = pos;
      return r;
   endfunction

endpackage

// ===== hw/rtl/esctok_step.sv =====
// ----------------------------------------------------------------------------
// esctok_step
// Next-state and token logic for one character: decodes the character in the
// current parser mode and produces up to three tokens plus the next state.
// ----------------------------------------------------------------------------
module esctok_step import esctok_pkg::*; (
   input  logic [15:0] char_code,
   input  logic        line_end,
   input  logic [15:0] char_index,
   input  state_type   cur,
   output step_type    nxt
);

   logic                      is_dec;
   logic                      is_hex;
   logic [3:0]                nibble;
   logic [6:0]                pause_two;
   logic [15:0]               colour_err_pos;

   assign is_dec = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign is_hex = is_dec || ((char_code >= CHAR_A) && (char_code <= CHAR_F));
   // Decimal digits carry their value in the low nibble; a..f are offset by nine.
   assign nibble = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);
   assign pause_two = (7'(cur.acc[3:0]) * 7'd10) + 7'(char_code[3:0]);
   assign colour_err_pos = cur.escape_start + 16'(cur.digit_count);

   always_comb begin
      rsp_type [BATCH_DEPTH-1:0] items;
      logic [1:0]                n;
      logic                      ended;
      logic                      handle;
      state_type                 ns;

      items  = '0;
      n      = 2'd0;
      ended  = 1'b0;
      handle = 1'b0;
      ns     = cur;

      unique case (cur.mode)
         MODE_NORMAL: begin
            handle = 1'b1;
         end
         MODE_ESCAPE: begin
            ns.mode = MODE_NORMAL;
            if (char_code == CHAR_N) begin
               items[n] = make_rsp(KIND_NEXTLINE, '0, '0, '0);
               n = n + 2'd1;
            end else if (char_code == CHAR_A) begin
               items[n] = make_rsp(KIND_CLEAN, '0, '0, '0);
               n = n + 2'd1;
            end else if (char_code == CHAR_DASH) begin
               items[n] = make_rsp(KIND_DELETE, '0, '0, '0);
               n = n + 2'd1;
            end else if (char_code == CHAR_LT) begin
               items[n] = make_rsp(KIND_ERASE, '0, '0, '0);
               n = n + 2'd1;
            end else if (char_code == CHAR_BACKSLASH) begin
               items[n] = make_rsp(KIND_BACKSLASH, '0, '0, '0);
               n = n + 2'd1;
            end else if (char_code == CHAR_P) begin
               ns.mode        = MODE_PAUSE_FIRST;
               ns.acc         = '0;
               ns.digit_count = '0;
            end else if (char_code == CHAR_C) begin
               ns.mode        = MODE_COLOUR;
               ns.acc         = '0;
               ns.digit_count = '0;
            end else begin
               items[n] = make_rsp(KIND_ERROR, '0, '0, cur.escape_start);
               n = n + 2'd1;
               ended = 1'b1;
            end
         end
         MODE_PAUSE_FIRST: begin
            if (is_dec) begin
               ns.acc         = 24'(char_code[3:0]);
               ns.digit_count = 3'd1;
               ns.mode        = MODE_PAUSE_MORE;
            end else begin
               items[n] = make_rsp(KIND_ERROR, '0, '0, cur.escape_start);
               n = n + 2'd1;
               ended = 1'b1;
            end
         end
         MODE_PAUSE_MORE: begin
            ns.mode = MODE_NORMAL;
            if (is_dec) begin
               items[n] = make_rsp(KIND_PAUSE, '0, 24'(pause_two), '0);
               n = n + 2'd1;
            end else begin
               // The pause ends here and the character is then taken as usual.
               items[n] = make_rsp(KIND_PAUSE, '0, cur.acc, '0);
               n = n + 2'd1;
               handle = 1'b1;
            end
         end
         MODE_COLOUR: begin
            if (is_hex) begin
               ns.acc         = {cur.acc[19:0], nibble};
               ns.digit_count = cur.digit_count + 3'd1;
               if (ns.digit_count >= COLOUR_DIGITS) begin
                  items[n] = make_rsp(KIND_COLOUR, '0, ns.acc, '0);
                  n = n + 2'd1;
                  ns.mode = MODE_NORMAL;
               end
            end else begin
               items[n] = make_rsp(KIND_ERROR, '0, '0, colour_err_pos);
               n = n + 2'd1;
               ended = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (handle) begin
         if (char_code == CHAR_NUL) begin
            items[n] = make_rsp(KIND_DONE, '0, '0, '0);
            n = n + 2'd1;
            ended = 1'b1;
         end else if (char_code == CHAR_NEWLINE) begin
            items[n] = make_rsp(KIND_NEXTLINE, '0, '0, '0);
            n = n + 2'd1;
         end else if (char_code == CHAR_BACKSLASH) begin
            ns.mode         = MODE_ESCAPE;
            ns.escape_start = char_index;
         end else begin
            items[n] = make_rsp(KIND_SYMBOL, char_code, '0, '0);
            n = n + 2'd1;
         end
      end

      if (line_end) begin
         // Close the line with a status token unless one was already given.
         if (!ended) begin
            unique case (ns.mode)
               MODE_NORMAL: begin
                  items[n] = make_rsp(KIND_DONE, '0, '0, '0);
                  n = n + 2'd1;
               end
               MODE_ESCAPE, MODE_PAUSE_FIRST: begin
                  items[n] = make_rsp(KIND_ERROR, '0, '0, ns.escape_start);
                  n = n + 2'd1;
               end
               MODE_PAUSE_MORE: begin
                  items[n] = make_rsp(KIND_PAUSE, '0, ns.acc, '0);
                  n = n + 2'd1;
                  items[n] = make_rsp(KIND_DONE, '0, '0, '0);
                  n = n + 2'd1;
               end
               MODE_COLOUR: begin
                  items[n] = make_rsp(KIND_ERROR, '0, '0,
                                      ns.escape_start + 16'(ns.digit_count));
                  n = n + 2'd1;
               end
               default: begin
               end
            endcase
         end
         ns.mode         = MODE_NORMAL;
         ns.digit_count  = '0;
         ns.acc          = '0;
         ns.escape_start = '0;
      end else if (ended) begin
         ns.mode = MODE_DRAIN;
      end

      nxt.state       = ns;
      nxt.batch.item  = items;
      nxt.batch.count = n;
   end

endmodule

// ===== hw/rtl/esctok_rspq.sv =====
// ----------------------------------------------------------------------------
// esctok_rspq
// Two-entry queue of token batches. Each entry holds all tokens of one
// request; tokens leave one per cycle unless stalled, last of a batch flagged.
// ----------------------------------------------------------------------------
module esctok_rspq import esctok_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  batch_type batch_in,
   output logic      full,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_head,
   output logic      rsp_run_last
);

   batch_type  batch_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] occ_ff;
   logic [1:0] occ_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic [1:0] head_count;
   logic       pop;
   logic       batch_done;

   assign full         = (occ_ff == 2'd2);
   assign rsp_valid    = (occ_ff != 2'd0);
   assign head_count   = batch_ff[rd_ptr_ff].count;
   assign rsp_head     = batch_ff[rd_ptr_ff].item[idx_ff];
   assign rsp_run_last = (idx_ff == (head_count - 2'd1));
   assign pop          = rsp_valid && !rsp_stall;
   assign batch_done   = pop && rsp_run_last;

   always_comb begin
      idx_in    = idx_ff;
      if (pop) begin
         idx_in = rsp_run_last ? 2'd0 : (idx_ff + 2'd1);
      end
      rd_ptr_in = rd_ptr_ff ^ batch_done;
      wr_ptr_in = wr_ptr_ff ^ push;
      occ_in    = occ_ff + {1'b0, push} - {1'b0, batch_done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         occ_ff    <= 2'd0;
         idx_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         batch_ff[wr_ptr_ff] <= batch_in;
      end
   end

endmodule

// ===== hw/rtl/escape_sequence_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_tokenizer_core
// Turns a line of 16-bit characters into symbol, command, pause, colour and
// status tokens, one character per request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Carries
//   req_      in         req_valid/req_stall  char_code, line_end
//   rsp_      out        rsp_valid/rsp_stall  kind, symbol_code, value,
//                                             error_position, run_last
//
// A request is decoded in the cycle it is accepted and its tokens (zero to
// three) are registered in a two-batch queue; they appear from the next cycle
// when no earlier batch is waiting. One request is taken per cycle while the
// queue has a free batch; a request that causes no token occupies nothing.
// Tokens leave at one per cycle while rsp_stall is low; req_stall rises only
// when two batches are waiting.
// Reset is synchronous and clears the parser state and the queue.
// ----------------------------------------------------------------------------
module escape_sequence_tokenizer_core import esctok_pkg::*; #(
   parameter int MAX_LINE_CHARS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_char_code,
   input  logic        req_line_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [15:0] rsp_symbol_code,
   output logic [23:0] rsp_value,
   output logic [15:0] rsp_error_position,
   output logic        rsp_run_last
);

   localparam logic [16:0] LastIndex = 17'(MAX_LINE_CHARS - 1);

   state_type   state_ff;
   state_type   state_in;
   logic [15:0] char_index_ff;
   logic [15:0] char_index_in;
   step_type    step;
   logic        accept;
   logic        full;
   rsp_type     head;

   assign accept    = req_valid && !full;
   assign req_stall = full;

   esctok_step u_step (
      .char_code  (req_char_code),
      .line_end   (req_line_end),
      .char_index (char_index_ff),
      .cur        (state_ff),
      .nxt        (step)
   );

   always_comb begin
      state_in      = state_ff;
      char_index_in = char_index_ff;
      if (accept) begin
         state_in = step.state;
         if (req_line_end) begin
            char_index_in = '0;
         end else if ({1'b0, char_index_ff} < LastIndex) begin
            // The index saturates at the longest supported line.
            char_index_in = char_index_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '{mode: MODE_NORMAL, digit_count: '0, acc: '0,
                            escape_start: '0};
         char_index_ff <= '0;
      end else begin
         state_ff      <= state_in;
         char_index_ff <= char_index_in;
      end
   end

   esctok_rspq u_rspq (
      .clock        (clock),
      .reset        (reset),
      .push         (accept && (step.batch.count != 2'd0)),
      .batch_in     (step.batch),
      .full         (full),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_head     (head),
      .rsp_run_last (rsp_run_last)
   );

   assign rsp_kind           = head.kind;
   assign rsp_symbol_code    = head.symbol_code;
   assign rsp_value          = head.value;
   assign rsp_error_position = head.error_position;

endmodule

// ===== hw/rtl/esctok_checker.sv =====
// ----------------------------------------------------------------------------
// esctok_checker
// Port-level checks of the tokenizer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module esctok_checker import esctok_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_kind,
   input logic [15:0] rsp_symbol_code,
   input logic [23:0] rsp_value,
   input logic [15:0] rsp_error_position,
   input logic        rsp_run_last
);

   // A status token always closes the tokens of its request.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == KIND_DONE) || (rsp_kind == KIND_ERROR))
      |-> rsp_run_last)
      else $error("status token not flagged as last of its request");

   // Only symbol tokens carry a character.
   a_symbol_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_SYMBOL) |-> (rsp_symbol_code == 16'd0))
      else $error("character on a token that is not a symbol");

   // Values belong to pause and colour tokens, and a pause stays below 100.
   a_value_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_COLOUR)
      |-> (rsp_value <= 24'd99) &&
          ((rsp_kind == KIND_PAUSE) || (rsp_value == 24'd0)))
      else $error("value out of place or pause out of range");

   // A position is reported with error tokens only.
   a_pos_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_ERROR) |-> (rsp_error_position == 16'd0))
      else $error("error position on a token that is not an error");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall
      |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value) &&
          $stable(rsp_run_last))
      else $error("stalled token changed");

endmodule

bind escape_sequence_tokenizer_core esctok_checker u_esctok_checker (.*);
